/* design/m3i_pkg.sv */
// Shared types and constants for the 3x3 matrix inverse block.
// Holds the cofactor operand tables and the queue status type.
// No dependencies.
package m3i_pkg;

  localparam int IO_BITS   = 32;
  localparam int NELEM     = 9;
  localparam int NDET      = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = 1;
  localparam int QCNT_BITS = 2;

  typedef logic [IO_BITS-1:0] io_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Element index: column-major, a11=0 a21=1 a31=2 a12=3 a22=4 a32=5 a13=6 a23=7 a33=8.
  // Cofactor k = a[PA]*a[PB] - a[QA]*a[QB], in output order.
  localparam int CF_PA [NELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int CF_PB [NELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int CF_QA [NELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int CF_QB [NELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  // The determinant expands along the first row: a11, a12, a13.
  localparam int DET_A [NDET] = '{0, 3, 6};

  // Diagonal positions of the result.
  localparam logic [NELEM-1:0] DIAG_MASK = 9'b100010001;

endpackage

/* design/m3i_front.sv */
// Front pipeline of the matrix inverse: cofactors, determinant, and
// classification of each matrix (singular, signs, magnitudes).
// Depends on m3i_pkg.
module m3i_front
  import m3i_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  io_word_t [NELEM-1:0]                  in_elem,
  output logic                                  out_valid,
  output logic [NELEM-1:0][2*WORD_BITS-1:0]     out_nmag,
  output logic [NELEM-1:0]                      out_nneg,
  output logic [3*WORD_BITS+1:0]                out_dmag,
  output logic                                  out_dneg,
  output logic                                  out_singular
);

  localparam int W  = WORD_BITS;
  localparam int AW = 2 * W;
  localparam int PW = 2 * W + 1;
  localparam int DW = 3 * W + 2;

  logic [6:0] v_r;

  logic signed [W-1:0]  s0_a_r  [NELEM];
  logic signed [AW-1:0] s1_p_r  [NELEM];
  logic signed [AW-1:0] s1_q_r  [NELEM];
  logic signed [W-1:0]  s1_a_r  [NDET];
  logic signed [AW-1:0] s2_adj_r [NELEM];
  logic signed [W-1:0]  s2_a_r  [NDET];
  logic signed [AW-1:0] s3_hi_r [NDET];
  logic signed [PW-1:0] s3_lo_r [NDET];
  logic signed [AW-1:0] s3_adj_r [NELEM];
  logic signed [DW-1:0] s4_t_r  [NDET];
  logic signed [AW-1:0] s4_adj_r [NELEM];
  logic signed [DW-1:0] s5_det_r;
  logic signed [AW-1:0] s5_adj_r [NELEM];
  logic [NELEM-1:0][AW-1:0] s6_nmag_r;
  logic [NELEM-1:0]         s6_nneg_r;
  logic [DW-1:0]            s6_dmag_r;
  logic                     s6_dneg_r;
  logic                     s6_sing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NELEM; k++) begin
        s0_a_r[k]   <= signed'(in_elem[k][W-1:0]);
        s1_p_r[k]   <= s0_a_r[CF_PA[k]] * s0_a_r[CF_PB[k]];
        s1_q_r[k]   <= s0_a_r[CF_QA[k]] * s0_a_r[CF_QB[k]];
        s2_adj_r[k] <= s1_p_r[k] - s1_q_r[k];
        s3_adj_r[k] <= s2_adj_r[k];
        s4_adj_r[k] <= s3_adj_r[k];
        s5_adj_r[k] <= s4_adj_r[k];
        s6_nneg_r[k] <= s5_adj_r[k][AW-1];
        s6_nmag_r[k] <= s5_adj_r[k][AW-1] ? AW'(-s5_adj_r[k]) : AW'(s5_adj_r[k]);
      end
      for (int j = 0; j < NDET; j++) begin
        s1_a_r[j]  <= s0_a_r[DET_A[j]];
        s2_a_r[j]  <= s1_a_r[j];
        // Split the cofactor into a signed upper and unsigned lower half.
        s3_hi_r[j] <= s2_a_r[j] * signed'(s2_adj_r[j][AW-1:W]);
        s3_lo_r[j] <= s2_a_r[j] * signed'({1'b0, s2_adj_r[j][W-1:0]});
        s4_t_r[j]  <= (DW'(s3_hi_r[j]) <<< W) + DW'(s3_lo_r[j]);
      end
      s5_det_r  <= s4_t_r[0] + s4_t_r[1] + s4_t_r[2];
      s6_sing_r <= (s5_det_r == '0);
      s6_dneg_r <= s5_det_r[DW-1];
      s6_dmag_r <= s5_det_r[DW-1] ? DW'(-s5_det_r) : DW'(s5_det_r);
    end
  end

  assign out_valid    = v_r[6];
  assign out_nmag     = s6_nmag_r;
  assign out_nneg     = s6_nneg_r;
  assign out_dmag     = s6_dmag_r;
  assign out_dneg     = s6_dneg_r;
  assign out_singular = s6_sing_r;

endmodule

/* design/m3i_queue.sv */
// Short request queue between the front and back pipelines.
// Register-based storage, one write and one read per cycle.
// Depends on m3i_pkg.
module m3i_queue
  import m3i_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] pop_data,
  output q_stat_t              stat
);

  logic [DATA_BITS-1:0] mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_BITS'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

/* design/m3i_back.sv */
// Back pipeline of the matrix inverse: nine restoring dividers, one
// quotient bit per stage, then sign, saturation and the singular case.
// Depends on m3i_pkg.
module m3i_back
  import m3i_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [NELEM-1:0][2*WORD_BITS-1:0] in_nmag,
  input  logic [NELEM-1:0]                  in_nneg,
  input  logic [3*WORD_BITS+1:0]            in_dmag,
  input  logic                              in_dneg,
  input  logic                              in_singular,
  output logic                              out_valid,
  output io_word_t [NELEM-1:0]              out_inv,
  output logic                              out_singular,
  output logic                              out_saturated
);

  localparam int W   = WORD_BITS;
  localparam int DW  = 3 * W + 2;
  localparam int NW  = 2 * W + 2 * FRAC_BITS;
  localparam int XW  = ((NW > DW + W) ? NW : DW + W) + 1;
  localparam int SH  = 2 * FRAC_BITS;
  localparam bit ONE_SAT = (FRAC_BITS >= W - 1);
  localparam logic [W-1:0] HALF    = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_VAL = ONE_SAT ? (HALF - 1'b1) : (W'(1) << FRAC_BITS);

  logic [W:0]        v_r;
  logic [W:0]        sing_r;
  logic [DW-1:0]     dm_r   [0:W-1];
  logic [XW-1:0]     rem_r  [0:W][NELEM];
  logic [W-1:0]      q_r    [0:W][NELEM];
  logic              ovf_r  [0:W][NELEM];
  logic              sgn_r  [0:W][NELEM];
  logic [XW:0]       diff_c [1:W][NELEM];

  logic              out_valid_r;
  io_word_t [NELEM-1:0] out_inv_r;
  io_word_t [NELEM-1:0] inv_c;
  logic              out_sing_r;
  logic              out_sat_r;
  logic              sat_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[W-1:0], in_valid};
    end
  end

  // Each stage tries dmag shifted to its quotient bit and keeps the difference
  // when it does not borrow.
  always_comb begin
    for (int s = 1; s <= W; s++) begin
      for (int k = 0; k < NELEM; k++) begin
        diff_c[s][k] = {1'b0, rem_r[s-1][k]} - {1'b0, XW'(dm_r[s-1]) << (W - s)};
      end
    end
  end

  always_ff @(posedge clk) begin
    dm_r[0]   <= in_dmag;
    sing_r[0] <= in_singular;
    for (int k = 0; k < NELEM; k++) begin
      rem_r[0][k] <= XW'(in_nmag[k]) << SH;
      q_r[0][k]   <= '0;
      ovf_r[0][k] <= ((XW'(in_nmag[k]) << SH) >= (XW'(in_dmag) << W));
      sgn_r[0][k] <= in_nneg[k] ^ in_dneg;
    end
    for (int s = 1; s < W; s++) begin
      dm_r[s] <= dm_r[s-1];
    end
    for (int s = 1; s <= W; s++) begin
      sing_r[s] <= sing_r[s-1];
      for (int k = 0; k < NELEM; k++) begin
        rem_r[s][k] <= diff_c[s][k][XW] ? rem_r[s-1][k] : diff_c[s][k][XW-1:0];
        q_r[s][k]   <= {q_r[s-1][k][W-2:0], ~diff_c[s][k][XW]};
        ovf_r[s][k] <= ovf_r[s-1][k];
        sgn_r[s][k] <= sgn_r[s-1][k];
      end
    end
  end

  always_comb begin
    logic          qneg;
    logic          lsat;
    logic [W-1:0]  lim;
    logic [W-1:0]  v;
    logic signed [W-1:0] res;
    sat_c = 1'b0;
    for (int k = 0; k < NELEM; k++) begin
      qneg = sgn_r[W][k] && (ovf_r[W][k] || (q_r[W][k] != '0));
      lim  = qneg ? HALF : HALF - 1'b1;
      lsat = ovf_r[W][k] || (q_r[W][k] > lim);
      v    = lsat ? lim : q_r[W][k];
      res  = qneg ? signed'(-v) : signed'(v);
      sat_c = sat_c | lsat;
      if (sing_r[W]) begin
        inv_c[k] = DIAG_MASK[k] ? IO_BITS'(ONE_VAL) : '0;
      end else begin
        inv_c[k] = IO_BITS'(res);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (v_r[W]) begin
      out_inv_r  <= inv_c;
      out_sing_r <= sing_r[W];
      out_sat_r  <= sing_r[W] ? ONE_SAT : sat_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_inv       = out_inv_r;
  assign out_singular  = out_sing_r;
  assign out_saturated = out_sat_r;

endmodule

/* design/matrix3_inverse.sv */
// Top level of the 3x3 matrix inverse (adjugate over determinant).
// Instantiates m3i_front, m3i_queue and m3i_back; uses m3i_pkg.
//
//   Channel   Ports                          Handshake
//   input     in_a_r1c1 .. in_a_r3c3         start high and busy low at a clock edge
//   result    out_inv_*, out_singular,       out_valid high for exactly one cycle
//             out_saturated
//
// One matrix is taken every cycle while busy is low. A result passes through
// seven front stages, one queue slot, one divider entry stage, WORD_BITS
// quotient-bit stages and the output register.
// The divider resolves one quotient bit per stage.
// Reset (rst_n low, synchronous) empties every stage and the queue.
// The receiver cannot stall; busy rises only if the queue fills.
module matrix3_inverse
  import m3i_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_a_r1c1,
  input  logic signed [31:0] in_a_r2c1,
  input  logic signed [31:0] in_a_r3c1,
  input  logic signed [31:0] in_a_r1c2,
  input  logic signed [31:0] in_a_r2c2,
  input  logic signed [31:0] in_a_r3c2,
  input  logic signed [31:0] in_a_r1c3,
  input  logic signed [31:0] in_a_r2c3,
  input  logic signed [31:0] in_a_r3c3,
  output logic               out_valid,
  output logic signed [31:0] out_inv_r1c1,
  output logic signed [31:0] out_inv_r2c1,
  output logic signed [31:0] out_inv_r3c1,
  output logic signed [31:0] out_inv_r1c2,
  output logic signed [31:0] out_inv_r2c2,
  output logic signed [31:0] out_inv_r3c2,
  output logic signed [31:0] out_inv_r1c3,
  output logic signed [31:0] out_inv_r2c3,
  output logic signed [31:0] out_inv_r3c3,
  output logic               out_singular,
  output logic               out_saturated
);

  localparam int AW = 2 * WORD_BITS;
  localparam int DW = 3 * WORD_BITS + 2;
  // Queue entry: singular flag, determinant sign and magnitude, cofactor
  // signs and magnitudes.
  localparam int QW = 2 + DW + NELEM + NELEM * AW;

  io_word_t [NELEM-1:0] in_elem;
  io_word_t [NELEM-1:0] out_inv;

  logic                       fe_en;
  logic                       fe_valid;
  logic [NELEM-1:0][AW-1:0]   fe_nmag;
  logic [NELEM-1:0]           fe_nneg;
  logic [DW-1:0]              fe_dmag;
  logic                       fe_dneg;
  logic                       fe_sing;

  logic [QW-1:0]              q_wdata;
  logic [QW-1:0]              q_rdata;
  q_stat_t                    q_stat;
  logic                       q_pop;

  logic [NELEM-1:0][AW-1:0]   be_nmag;
  logic [NELEM-1:0]           be_nneg;
  logic [DW-1:0]              be_dmag;
  logic                       be_dneg;
  logic                       be_sing;

  // Column-major element order, index 0 is row 1 column 1.
  assign in_elem = {in_a_r3c3, in_a_r2c3, in_a_r1c3,
                    in_a_r3c2, in_a_r2c2, in_a_r1c2,
                    in_a_r3c1, in_a_r2c1, in_a_r1c1};

  // The front pipeline moves as one; it halts only while the queue is full,
  // and that is exactly when a new request is refused.
  assign fe_en = !q_stat.full;
  assign busy  = q_stat.full;

  m3i_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (fe_en),
    .in_valid     (start),
    .in_elem      (in_elem),
    .out_valid    (fe_valid),
    .out_nmag     (fe_nmag),
    .out_nneg     (fe_nneg),
    .out_dmag     (fe_dmag),
    .out_dneg     (fe_dneg),
    .out_singular (fe_sing)
  );

  assign q_wdata = {fe_sing, fe_dneg, fe_dmag, fe_nneg, fe_nmag};

  // The back pipeline never stalls, so it drains one entry whenever one waits.
  assign q_pop = !q_stat.empty;

  m3i_queue #(
    .DATA_BITS (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fe_valid && fe_en),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  assign {be_sing, be_dneg, be_dmag, be_nneg, be_nmag} = q_rdata;

  m3i_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (q_pop),
    .in_nmag       (be_nmag),
    .in_nneg       (be_nneg),
    .in_dmag       (be_dmag),
    .in_dneg       (be_dneg),
    .in_singular   (be_sing),
    .out_valid     (out_valid),
    .out_inv       (out_inv),
    .out_singular  (out_singular),
    .out_saturated (out_saturated)
  );

  assign out_inv_r1c1 = out_inv[0];
  assign out_inv_r2c1 = out_inv[1];
  assign out_inv_r3c1 = out_inv[2];
  assign out_inv_r1c2 = out_inv[3];
  assign out_inv_r2c2 = out_inv[4];
  assign out_inv_r3c2 = out_inv[5];
  assign out_inv_r1c3 = out_inv[6];
  assign out_inv_r2c3 = out_inv[7];
  assign out_inv_r3c3 = out_inv[8];

`ifndef ASSERT_OFF
  // Every taken request comes out with out_valid after passing the whole pipeline.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(WORD_BITS + 10) out_valid)
    else $error("result missing after fixed latency");

  // A singular matrix yields the identity: the off-diagonal entries checked here are zero.
  a_sing_offdiag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_inv_r2c1 == '0 && out_inv_r1c2 == '0 &&
                                  out_inv_r3c2 == '0 && out_inv_r2c3 == '0)
    else $error("singular result is not diagonal");

  // The identity's diagonal entries are all equal.
  a_sing_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_inv_r1c1 == out_inv_r2c2 &&
                                  out_inv_r2c2 == out_inv_r3c3)
    else $error("singular result has unequal diagonal");
`endif

endmodule

/* tb/matrix3_inverse_check.sv */
// Checker for the 3x3 matrix inverse: predicts each inverse from the request
// and compares it with the result channel. Depends on matrix3_inverse ports only.
`timescale 1ns / 100ps
module matrix3_inverse_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] a [9],
  input  logic               out_valid,
  input  logic signed [31:0] inv [9],
  input  logic               out_singular,
  input  logic               out_saturated,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] e [9];
    logic               singular;
    logic               saturated;
  } inverse_t;

  inverse_t expected_inverses[$];

  localparam logic signed [63:0] WMAX = 64'sd2147483647;
  localparam logic signed [63:0] WMIN = -64'sd2147483648;

  function automatic inverse_t compute_inverse(logic signed [31:0] m [9]);
    inverse_t r;
    logic signed [63:0] x [9];
    logic signed [63:0] cof [9];
    logic signed [127:0] det;
    logic [127:0] dmag, nmag, q;
    logic qneg;
    for (int i = 0; i < 9; i++) x[i] = m[i];
    // Column-major indexes: a11=0 a21=1 a31=2 a12=3 a22=4 a32=5 a13=6 a23=7 a33=8.
    cof[0] = x[4] * x[8] - x[7] * x[5];
    cof[1] = x[7] * x[2] - x[1] * x[8];
    cof[2] = x[1] * x[5] - x[4] * x[2];
    cof[3] = x[6] * x[5] - x[3] * x[8];
    cof[4] = x[0] * x[8] - x[6] * x[2];
    cof[5] = x[3] * x[2] - x[0] * x[5];
    cof[6] = x[3] * x[7] - x[6] * x[4];
    cof[7] = x[6] * x[1] - x[0] * x[7];
    cof[8] = x[0] * x[4] - x[3] * x[1];
    det = 128'(x[0]) * 128'(cof[0]) + 128'(x[3]) * 128'(cof[1])
        + 128'(x[6]) * 128'(cof[2]);
    r.saturated = 1'b0;
    r.singular = (det == 0);
    if (r.singular) begin
      for (int i = 0; i < 9; i++) r.e[i] = (i % 4 == 0) ? 32'sh0001_0000 : '0;
      return r;
    end
    dmag = det < 0 ? -det : det;
    for (int i = 0; i < 9; i++) begin
      nmag = (cof[i] < 0) ? 128'(-128'(cof[i])) : 128'(cof[i]);
      q = (nmag << 32) / dmag;
      qneg = ((cof[i] < 0) != (det < 0)) && (q != 0);
      if (!qneg && q > 128'(WMAX)) begin
        r.e[i] = WMAX[31:0];
        r.saturated = 1'b1;
      end else if (qneg && q > 128'(64'sd2147483648)) begin
        r.e[i] = WMIN[31:0];
        r.saturated = 1'b1;
      end else begin
        r.e[i] = qneg ? -q[31:0] : q[31:0];
      end
    end
    return r;
  endfunction

  assign pending = expected_inverses.size();

  initial fail_count = 0;

  // Mismatches of one result are tallied locally and added in one update.
  always @(posedge clk) begin
    inverse_t want;
    int errs;
    errs = 0;
    if (rst_n && start && !busy) expected_inverses.push_back(compute_inverse(a));
    if (rst_n && out_valid) begin
      if (expected_inverses.size() == 0) begin
        $error("result with no request waiting");
        errs++;
      end else begin
        want = expected_inverses.pop_front();
        for (int i = 0; i < 9; i++)
          if (inv[i] !== want.e[i]) begin
            $error("inv[%0d] expected %h got %h", i, want.e[i], inv[i]);
            errs++;
          end
        if (out_singular !== want.singular) begin
          $error("singular expected %b got %b", want.singular, out_singular);
          errs++;
        end
        if (out_saturated !== want.saturated) begin
          $error("saturated expected %b got %b", want.saturated, out_saturated);
          errs++;
        end
      end
    end
    if (errs != 0) fail_count <= fail_count + errs;
  end

endmodule

/* tb/matrix3_inverse_test.sv */
// Top of the matrix inverse testbench: clock, reset, stimulus and verdict.
// Depends on matrix3_inverse and matrix3_inverse_check.
`timescale 1ns / 100ps
module matrix3_inverse_test;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] a [9];
  logic out_valid, out_singular, out_saturated;
  logic signed [31:0] inv [9];
  int fail_count, pending;
  int idle_cycles = 0;

  localparam int LATENCY = 42;
  localparam int WATCHDOG_LIMIT = 2000;

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial for (int i = 0; i < 9; i++) a[i] = '0;

  matrix3_inverse dut (
    .clk, .rst_n, .start, .busy,
    .in_a_r1c1(a[0]), .in_a_r2c1(a[1]), .in_a_r3c1(a[2]),
    .in_a_r1c2(a[3]), .in_a_r2c2(a[4]), .in_a_r3c2(a[5]),
    .in_a_r1c3(a[6]), .in_a_r2c3(a[7]), .in_a_r3c3(a[8]),
    .out_valid,
    .out_inv_r1c1(inv[0]), .out_inv_r2c1(inv[1]), .out_inv_r3c1(inv[2]),
    .out_inv_r1c2(inv[3]), .out_inv_r2c2(inv[4]), .out_inv_r3c2(inv[5]),
    .out_inv_r1c3(inv[6]), .out_inv_r2c3(inv[7]), .out_inv_r3c3(inv[8]),
    .out_singular, .out_saturated
  );

  matrix3_inverse_check checker_i (
    .clk, .rst_n, .start, .busy, .a, .out_valid, .inv,
    .out_singular, .out_saturated, .fail_count, .pending
  );

  // The watchdog counts cycles with neither a request nor a result taken.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Random element with a bias toward small values, edges and zero, so that
  // determinants stay in range often enough to exercise ordinary quotients.
  function automatic logic [31:0] random_element();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3, 4: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      5, 6: return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
      default: return $urandom;
    endcase
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(input logic [31:0] m [9]);
    for (int i = 0; i < 9; i++) a[i] <= m[i];
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    logic [31:0] m [9];
    int burst;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: identity, zero matrix (singular), a scaled diagonal, a dependent
    // matrix, tiny determinant for saturation, full-scale extremes and two mixed matrices.
    for (int t = 0; t < 12; t++) begin
      for (int i = 0; i < 9; i++) begin
        case (t)
          0: m[i] = (i % 4 == 0) ? 32'h0001_0000 : '0;
          1: m[i] = '0;
          2: m[i] = (i % 4 == 0) ? 32'h0002_0000 : '0;
          3: m[i] = 32'h0001_0000 * (i % 3 + 1);
          4: m[i] = (i % 4 == 0) ? 32'h0000_0001 : '0;
          5: m[i] = (i % 4 == 0) ? 32'h8000_0000 : '0;
          6: m[i] = (i % 4 == 0) ? 32'h7fff_ffff : '0;
          7: m[i] = 32'h7fff_ffff;
          8: m[i] = 32'hffff_ffff;
          9: m[i] = (i % 4 == 0) ? 32'hffff_0000 : (i == 1 ? 32'h0003_0000 : '0);
          10: m[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
          default: m[i] = (i % 4 == 0) ? 32'h0100_0000 : 32'h0000_0100;
        endcase
      end
      send_request(m);
    end
    idle_gap(3);

    // Random part in bursts; some requests repeat the first column to hit singular.
    for (int n = 0; n < 1800;) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++, n++) begin
        for (int i = 0; i < 9; i++) m[i] = random_element();
        if ($urandom_range(0, 9) == 0)
          for (int i = 0; i < 3; i++) m[i + 3] = m[i];
        send_request(m);
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
design/m3i_pkg.sv
design/m3i_front.sv
design/m3i_queue.sv
design/m3i_back.sv
design/matrix3_inverse.sv
tb/matrix3_inverse_check.sv
tb/matrix3_inverse_test.sv
